// File: rtl/calendar_date_normalizer_assert.svh
// Assertion macros shared by the block's checker.
`ifndef CALENDAR_DATE_NORMALIZER_ASSERT_SVH
`define CALENDAR_DATE_NORMALIZER_ASSERT_SVH

// Condition must hold in the same cycle as the trigger.
`define CDN_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition must hold in the cycle after the trigger.
`define CDN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/cdn_pkg.sv
package cdn_pkg;

    localparam int unsigned MonthsPerYear = 12;
    localparam int unsigned InWidth = 40;
    localparam int unsigned OutWidth = 40;

    // (m - 1) / 12 for m - 1 up to 254 as (x * 171) >> 11.
    localparam logic [7:0] FoldRecip = 8'd171;
    localparam int unsigned FoldShift = 11;

    // y / 25 for 16-bit y as (y * 83887) >> 21.
    localparam logic [16:0] Mod25Recip = 17'd83887;
    localparam int unsigned Mod25Shift = 21;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_MONTH_ZERO = 2'd1,
        ST_OVERFLOW   = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD_Q,
        S_MOD_R,
        S_STEP,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic mod_q;
        logic mod_r;
        logic step;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic err;
        logic fits;
        logic out_free;
    } t_dp_stat;

    function automatic logic [4:0] f_month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        begin
            unique case (month)
                4'd2:                         len = leap ? 5'd29 : 5'd28;
                4'd4, 4'd6, 4'd9, 4'd11:      len = 5'd30;
                default:                      len = 5'd31;
            endcase
            return len;
        end
    endfunction

endpackage

// File: rtl/cdn_ctrl.sv
module cdn_ctrl
    import cdn_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_dp_stat i_stat,
    output logic     o_in_ready,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MOD_Q;
                end
            end
            S_MOD_Q: begin
                // A month of zero or an overflow while folding ends the item here.
                if (i_stat.err) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.mod_q = 1'b1;
                    n_state     = S_MOD_R;
                end
            end
            S_MOD_R: begin
                o_cmd.mod_r = 1'b1;
                n_state     = S_STEP;
            end
            S_STEP: begin
                if (i_stat.err || i_stat.fits) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// File: rtl/cdn_dp.sv
module cdn_dp
    import cdn_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    input  logic [InWidth-1:0]  i_in_data,
    input  logic                i_out_ready,
    output t_dp_stat            o_stat,
    output logic                o_out_valid,
    output logic [OutWidth-1:0] o_out_data
);

    logic [15:0]         r_year;
    logic [3:0]          r_month;
    logic [15:0]         r_day;
    t_status             r_status;
    logic [11:0]         r_q25;
    logic [4:0]          r_r25;
    logic                r_out_valid;
    logic [OutWidth-1:0] r_out_data;

    logic [15:0] in_year;
    logic [7:0]  in_month;
    logic [15:0] in_day;
    logic [7:0]  m_minus1;
    logic [15:0] fold_prod;
    logic [4:0]  fold_q;
    logic [7:0]  fold_r;
    logic [16:0] fold_year;
    logic [32:0] q25_prod;
    logic [15:0] q25_times25;
    logic [15:0] r25_full;
    logic        leap;
    logic [4:0]  len;
    logic [15:0] day_less;

    assign in_year  = i_in_data[15:0];
    assign in_month = i_in_data[23:16];
    assign in_day   = i_in_data[39:24];

    // Months above twelve fold into whole years.
    assign m_minus1  = in_month - 8'd1;
    assign fold_prod = 16'(m_minus1 * FoldRecip);
    assign fold_q    = fold_prod[FoldShift+4:FoldShift];
    assign fold_r    = m_minus1 - ({3'd0, fold_q} << 3) - ({3'd0, fold_q} << 2);
    assign fold_year = {1'b0, in_year} + {12'd0, fold_q};

    assign q25_prod    = 33'(r_year * Mod25Recip);
    assign q25_times25 = ({4'd0, r_q25} << 4) + ({4'd0, r_q25} << 3) + {4'd0, r_q25};
    assign r25_full    = r_year - q25_times25;

    // Century years are divisible by 4 and 25; leap centuries also by 16.
    assign leap     = (r_year[1:0] == 2'd0) && ((r_r25 != 5'd0) || (r_year[3:0] == 4'd0));
    assign len      = f_month_len(r_month, leap);
    assign day_less = r_day - {11'd0, len};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_day <= in_day;
            if (in_month == 8'd0) begin
                r_year   <= in_year;
                r_month  <= 4'd0;
                r_status <= ST_MONTH_ZERO;
            end else begin
                r_month <= 4'(fold_r + 8'd1);
                if (fold_year[16]) begin
                    r_year   <= 16'hFFFF;
                    r_status <= ST_OVERFLOW;
                end else begin
                    r_year   <= fold_year[15:0];
                    r_status <= ST_OK;
                end
            end
        end
        if (i_cmd.mod_q) begin
            r_q25 <= q25_prod[Mod25Shift+11:Mod25Shift];
        end
        if (i_cmd.mod_r) begin
            r_r25 <= r25_full[4:0];
        end
        if (i_cmd.step) begin
            r_day <= day_less;
            if (r_month == 4'(MonthsPerYear)) begin
                r_month <= 4'd1;
                if (r_year == 16'hFFFF) begin
                    r_status <= ST_OVERFLOW;
                end else begin
                    r_year <= r_year + 16'd1;
                    r_r25  <= (r_r25 == 5'd24) ? 5'd0 : r_r25 + 5'd1;
                end
            end else begin
                r_month <= r_month + 4'd1;
            end
        end
        if (i_cmd.out_load) begin
            r_out_data <= {2'd0, r_status, r_day, r_month, r_year};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.err      = (r_status != ST_OK);
    assign o_stat.fits     = (r_day <= {11'd0, len});
    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out_data;

endmodule

// File: rtl/calendar_date_normalizer.sv
// Normalizes a Gregorian date whose month and day may be out of range. One item is
// worked on at a time. The month folds into the year as the item is accepted, and the
// states MOD_Q and MOD_R then find the year modulo 25 for the leap rule. State STEP
// then steps the day back by one month at a time until the day is found to fit, and
// state FINISH loads the result register; the next item is taken only after that load.
// The months stepped over reach about 2160 for a day of 65535. A result waits in the
// output register until taken, and only the final load of the following item waits
// behind it. A month of zero skips to FINISH and returns status 1, without normalizing;
// a carry past year 65535 returns status 2 with the year saturated.
module calendar_date_normalizer
    import cdn_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    // year_in [15:0], month_in [23:16], day_in [39:24]
    input  logic [InWidth-1:0]  i_s_axis_tdata,
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    // year_out [15:0], month_out [19:16], day_out [35:20], status [37:36], zeros above
    output logic [OutWidth-1:0] o_m_axis_tdata
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    cdn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_stat     (stat),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (cmd)
    );

    cdn_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_s_axis_tdata),
        .i_out_ready (i_m_axis_tready),
        .o_stat      (stat),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_data  (o_m_axis_tdata)
    );

endmodule

// File: rtl/cdn_checker.sv
`include "calendar_date_normalizer_assert.svh"

module cdn_checker
    import cdn_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_s_axis_tvalid,
    input logic                i_s_axis_tready,
    input logic [InWidth-1:0]  i_s_axis_tdata,
    input logic                i_m_axis_tvalid,
    input logic                i_m_axis_tready,
    input logic [OutWidth-1:0] i_m_axis_tdata
);

    logic [3:0] out_month;
    logic [1:0] out_status;
    logic [15:0] out_day;
    logic        month_ok;
    logic        status_ok;
    logic        ok_valid;
    logic        out_stall;
    logic        in_stall;
    logic [OutWidth:0] out_bus;
    logic [InWidth:0]  in_bus;

    assign out_month  = i_m_axis_tdata[19:16];
    assign out_status = i_m_axis_tdata[37:36];
    assign out_day    = i_m_axis_tdata[35:20];

    // Only a month-zero error reports month 0; every result month stays within a year.
    assign month_ok  = (out_month <= 4'd12) &&
                       ((out_month == 4'd0) == (out_status == ST_MONTH_ZERO));
    assign status_ok = (out_status == ST_OK) || (out_status == ST_MONTH_ZERO) ||
                       (out_status == ST_OVERFLOW);
    assign ok_valid  = i_m_axis_tvalid && (out_status == ST_OK);
    assign out_stall = i_m_axis_tvalid && !i_m_axis_tready;
    assign in_stall  = i_s_axis_tvalid && !i_s_axis_tready;
    assign out_bus   = {i_m_axis_tvalid, i_m_axis_tdata};
    assign in_bus    = {i_s_axis_tvalid, i_s_axis_tdata};

    `CDN_ASSERT_SAME(a_month_range, i_clk, i_rst_n, i_m_axis_tvalid, month_ok, "bad month")

    `CDN_ASSERT_SAME(a_status_code, i_clk, i_rst_n, i_m_axis_tvalid, status_ok, "bad status")

    // A normalized date without error has a day of at most 31.
    `CDN_ASSERT_SAME(a_day_fits, i_clk, i_rst_n, ok_valid, out_day <= 16'd31, "day too large")

    `CDN_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, $stable(out_bus), "result changed")

    // A waiting input item stays in place until it is taken.
    `CDN_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, in_stall, $stable(in_bus), "input item changed")

endmodule

bind calendar_date_normalizer cdn_checker u_cdn_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .i_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .i_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .i_m_axis_tdata  (o_m_axis_tdata)
);
